FILE: sv/mandelbrot_escape_test_macros.svh
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_macros
// Assertion macros shared by the escape-time block.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TEST_MACROS_SVH
`define MANDELBROT_ESCAPE_TEST_MACROS_SVH

// same-cycle implication
`define MBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, widths and helpers for the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int PIX_W       = 12;
    localparam int DIM_W       = 13;
    localparam int LIMIT_W     = 16;
    localparam int FRAC_BITS   = 28;
    localparam int COORD_W     = 32;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int DIVIDEND_W  = PIX_W + FRAC_BITS + 1;
    localparam int WIDE_W      = DIVIDEND_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(64);
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(64);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(256);

    // real axis starts at -1.5, imaginary at -1.0
    localparam logic signed [WIDE_W-1:0] RE_OFFSET = WIDE_W'(64'd3 << (FRAC_BITS - 1));
    localparam logic signed [WIDE_W-1:0] IM_OFFSET = WIDE_W'(64'd1 << FRAC_BITS);

    localparam logic signed [WIDE_W-1:0] WIDE_MAX =
        {{(WIDE_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = ~WIDE_MAX;

    // |z|^2 >= 4 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_BOUND = PROD_W'(64'd1 << (2 * FRAC_BITS + 2));

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t re;
        coord_t im;
    } point_t;

    typedef struct packed {
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   width;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] x);
        coord_t r;
        if (x > WIDE_MAX)
        begin
            r = {1'b0, {(COORD_W - 1){1'b1}}};
        end
        else if (x < WIDE_MIN)
        begin
            r = {1'b1, {(COORD_W - 1){1'b0}}};
        end
        else
        begin
            r = x[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/mbe_div.sv
// ----------------------------------------------------------------------------
// mbe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbe_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mbe_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [mbe_pkg::DIM_W-1:0]      divisor,
    output logic                           done,
    output logic [mbe_pkg::DIVIDEND_W-1:0] quotient
);
    import mbe_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIM_W-1:0]      dsr_reg;
    logic [DIM_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIM_W:0]        rem_sh;
    logic [DIM_W:0]        rem_sub;
    logic                  ge;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
            dvd_next  = {dvd_reg[DIVIDEND_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: sv/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Takes a pixel and maps it to a point c in Q4.28, then queues it.
// ----------------------------------------------------------------------------
module mbe_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mbe_pkg::PIX_W-1:0] pixel_row,
    input  logic [mbe_pkg::PIX_W-1:0] pixel_column,
    input  mbe_pkg::cfg_t             cfg,
    input  logic                      q_full,
    output logic                      busy,
    output logic                      push,
    output mbe_pkg::point_t           point
);
    import mbe_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    point_t       point_reg;
    logic         accept;
    logic         re_done, im_done;
    logic [DIVIDEND_W-1:0] re_q, im_q;
    logic [DIM_W-1:0]      width_c, height_c;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(d) > MAX_DIMENSION)
        begin
            r = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    assign accept   = start && (state_reg == F_IDLE);
    assign width_c  = clamp_dim(cfg.width);
    assign height_c = clamp_dim(cfg.height);

    mbe_div u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend ({pixel_column, {(FRAC_BITS + 1){1'b0}}}),
        .divisor  (width_c),
        .done     (re_done),
        .quotient (re_q)
    );

    mbe_div u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend ({pixel_row, {(FRAC_BITS + 1){1'b0}}}),
        .divisor  (height_c),
        .done     (im_done),
        .quotient (im_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (re_done && im_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_DIV && re_done && im_done)
        begin
            point_reg.re <= sat_coord($signed({1'b0, re_q}) - RE_OFFSET);
            point_reg.im <= sat_coord($signed({1'b0, im_q}) - IM_OFFSET);
        end
    end

    assign busy  = (state_reg != F_IDLE);
    assign push  = (state_reg == F_PUSH) && !q_full;
    assign point = point_reg;

endmodule

FILE: sv/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// Short FIFO of mapped points between front and back.
// ----------------------------------------------------------------------------
module mbe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mbe_pkg::point_t     push_data,
    input  logic                pop,
    output mbe_pkg::point_t     head,
    output mbe_pkg::q_status_t  status
);
    import mbe_pkg::*;

    point_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

FILE: sv/mbe_back.sv
// ----------------------------------------------------------------------------
// mbe_back
// Iterates z = z*z + c until escape or the iteration limit.
// ----------------------------------------------------------------------------
module mbe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mbe_pkg::LIMIT_W-1:0] limit,
    input  mbe_pkg::point_t             head,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        done,
    output logic                        inside_res
);
    import mbe_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_TEST = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    coord_t      zr_reg, zi_reg, cr_reg, ci_reg;
    logic [LIMIT_W-1:0] n_reg, n_inc;
    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg;
    logic signed [PROD_W-1:0] diff;
    logic signed [WIDE_W-1:0] zr_wide, zi_wide;
    logic [PROD_W-1:0] mag;
    logic escaped, at_limit;
    logic done_reg, done_next;
    logic inside_reg, inside_next;

    always_comb
    begin
        mag      = $unsigned(rr_reg) + $unsigned(ii_reg);
        escaped  = mag >= ESCAPE_BOUND;
        n_inc    = n_reg + LIMIT_W'(1);
        at_limit = n_inc >= limit;
        diff     = rr_reg - ii_reg;
        zr_wide  = WIDE_W'($signed(diff[PROD_W-1:FRAC_BITS])) + WIDE_W'(cr_reg);
        zi_wide  = WIDE_W'($signed(ri_reg[PROD_W-1:FRAC_BITS-1])) + WIDE_W'(ci_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        inside_next = inside_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_TEST;
            end
            B_TEST:
            begin
                if (escaped)
                begin
                    state_next  = B_IDLE;
                    done_next   = 1'b1;
                    inside_next = (n_reg == limit);
                end
                else if (at_limit)
                begin
                    state_next  = B_IDLE;
                    done_next   = 1'b1;
                    inside_next = (n_inc == limit);
                end
                else
                begin
                    state_next = B_MUL;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
        if (state_reg == B_IDLE && !q_empty)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
            n_reg  <= '0;
            cr_reg <= head.re;
            ci_reg <= head.im;
        end
        if (state_reg == B_MUL)
        begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end
        if (state_reg == B_TEST && !escaped)
        begin
            n_reg  <= n_inc;
            zr_reg <= sat_coord(zr_wide);
            zi_reg <= sat_coord(zi_wide);
        end
    end

    assign pop        = (state_reg == B_IDLE) && !q_empty;
    assign done       = done_reg;
    assign inside_res = inside_reg;

endmodule

FILE: sv/mandelbrot_escape_test.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_test
// Escape-time test of one pixel against the Mandelbrot set.
// ----------------------------------------------------------------------------
// A pixel item is taken when start is high and busy is low. Mapping the pixel
// to c runs two serial dividers side by side, one quotient bit per cycle, so
// busy stays high while the 41 quotient bits are formed, c is registered and
// the point is pushed, and longer while the queue is full; a two-entry queue
// then hands the point to the iteration engine, which runs each iteration as
// a multiply step followed by a test-and-update step. The slower of the
// mapping and the iteration engine sets the sustained rate. The result
// appears on inside_res with done high for exactly one cycle, and inside_res
// holds it until the next result; results come back in input order and
// cannot be stalled by the receiver.
module mandelbrot_escape_test #(
    parameter int MAX_DIMENSION  = 4096,
    parameter int MAX_ITERATIONS = 65535
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mbe_pkg::PIX_W-1:0]  pixel_row,
    input  logic [mbe_pkg::PIX_W-1:0]  pixel_column,
    output logic                       done,
    output logic                       inside_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0] paddr,
    input  logic [mbe_pkg::DATA_W-1:0] pwdata,
    output logic [mbe_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mbe_pkg::*;

    `include "mandelbrot_escape_test_macros.svh"

    cfg_t               cfg_reg;
    logic [LIMIT_W-1:0] limit_eff;
    logic               cfg_wr;
    logic               q_push, q_pop;
    point_t             q_in, q_head;
    q_status_t          q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height <= HEIGHT_RESET;
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.limit  <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_HEIGHT: cfg_reg.height <= pwdata[DIM_W-1:0];
                REG_WIDTH:  cfg_reg.width  <= pwdata[DIM_W-1:0];
                REG_LIMIT:  cfg_reg.limit  <= pwdata[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HEIGHT: prdata = DATA_W'(cfg_reg.height);
            REG_WIDTH:  prdata = DATA_W'(cfg_reg.width);
            REG_LIMIT:  prdata = DATA_W'(cfg_reg.limit);
            default:    prdata = '0;
        endcase
    end

    assign limit_eff = (32'(cfg_reg.limit) > MAX_ITERATIONS) ?
                       LIMIT_W'(MAX_ITERATIONS) : cfg_reg.limit;

    mbe_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .cfg          (cfg_reg),
        .q_full       (q_stat.full),
        .busy         (busy),
        .push         (q_push),
        .point        (q_in)
    );

    mbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_stat)
    );

    mbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit_eff),
        .head       (q_head),
        .q_empty    (q_stat.empty),
        .pop        (q_pop),
        .done       (done),
        .inside_res (inside_res)
    );

    `MBE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `MBE_ASSERT_NOW(a_push_room, clk, rst_n, q_push, !q_stat.full)
    `MBE_ASSERT_NOW(a_pop_data, clk, rst_n, q_pop, !q_stat.empty)
    `MBE_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)

endmodule

FILE: test/mandelbrot_escape_test_test.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_test
// Self-checking bench for the Mandelbrot escape-time pixel test.
// ----------------------------------------------------------------------------
// Pixels go in through the start/busy handshake and image size and iteration
// limit are set over APB. A scoreboard maps each pixel to c in Q4.28, runs
// the escape iteration in the design's fixed-point arithmetic and keeps the
// expected in-set flag in order. Each done strobe is checked against the oldest entry. A directed
// pass covers corner pixels, zero and oversized dimensions and the limits
// 0, 1, 2 and 65535. Random phases follow, each with its own register set.
// ----------------------------------------------------------------------------
import mbe_pkg::*;

class escape_board #(int MAX_DIM = 4096, int MAX_ITER = 65535);

    typedef longint unsigned u64_t;

    typedef struct {
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
        bit               in_set;
    } pixel_note_t;

    cfg_t          cfg;
    pixel_note_t   expected_pixels[$];
    int unsigned   mismatch_count;

    function new();
        cfg.height     = HEIGHT_RESET;
        cfg.width      = WIDTH_RESET;
        cfg.limit      = LIMIT_RESET;
        mismatch_count = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [DATA_W-1:0] value);
        case (index)
            REG_HEIGHT: cfg.height = value[DIM_W-1:0];
            REG_WIDTH:  cfg.width  = value[DIM_W-1:0];
            REG_LIMIT:  cfg.limit  = value[LIMIT_W-1:0];
            default:    ;
        endcase
    endfunction

    function int unsigned pending();
        return expected_pixels.size();
    endfunction

    static function coord_t clip(longint x);
        if (x > longint'(32'sh7FFF_FFFF))
        begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -longint'(64'sh8000_0000))
        begin
            return 32'sh8000_0000;
        end
        return coord_t'(x);
    endfunction

    function coord_t map_axis(logic [PIX_W-1:0] idx, logic [DIM_W-1:0] dim, longint offset);
        u64_t d;
        u64_t scaled;
        d = u64_t'(dim);
        if (d == 0)
        begin
            d = 1;
        end
        else if (d > MAX_DIM)
        begin
            d = MAX_DIM;
        end
        scaled = (u64_t'(idx) << (FRAC_BITS + 1)) / d;
        return clip(longint'(scaled) - offset);
    endfunction

    function bit escape_test(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
        coord_t          cr;
        coord_t          ci;
        coord_t          zr;
        coord_t          zi;
        longint          rr;
        longint          ii;
        longint          ri;
        u64_t            mag;
        int unsigned     lim;
        int unsigned     n;
        lim = 32'(cfg.limit);
        if (lim > MAX_ITER)
        begin
            lim = MAX_ITER;
        end
        cr = map_axis(col, cfg.width, longint'(3) << (FRAC_BITS - 1));
        ci = map_axis(row, cfg.height, longint'(1) << FRAC_BITS);
        zr = 0;
        zi = 0;
        n  = 0;
        while (1)
        begin
            rr  = longint'(zr) * longint'(zr);
            ii  = longint'(zi) * longint'(zi);
            mag = u64_t'(rr) + u64_t'(ii);
            if (mag >= ESCAPE_BOUND)
            begin
                break;
            end
            n++;
            if (n >= lim)
            begin
                break;
            end
            ri = longint'(zr) * longint'(zi);
            zr = clip(((rr - ii) >>> FRAC_BITS) + longint'(cr));
            zi = clip(((ri * 2) >>> FRAC_BITS) + longint'(ci));
        end
        return n == lim;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
        pixel_note_t p;
        p.row    = row;
        p.col    = col;
        p.in_set = escape_test(row, col);
        expected_pixels.push_back(p);
    endfunction

    function void check_result(logic in_set);
        pixel_note_t p;
        if (expected_pixels.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("ERROR: result with no pixel pending, inside_res=%0b", in_set);
            end
        end
        else
        begin
            p = expected_pixels.pop_front();
            if (in_set !== p.in_set)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("ERROR: pixel row=%0d col=%0d h=%0d w=%0d limit=%0d: expected %0b got %0b",
                             p.row, p.col, cfg.height, cfg.width, cfg.limit, p.in_set, in_set);
                end
            end
        end
    endfunction

endclass

module mandelbrot_escape_test_test;

    localparam int MAX_DIMENSION  = 4096;
    localparam int MAX_ITERATIONS = 65535;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_column;
    logic               done;
    logic               inside_res;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    escape_board #(MAX_DIMENSION, MAX_ITERATIONS) board;
    bit idle_on;

    mandelbrot_escape_test #(
        .MAX_DIMENSION  (MAX_DIMENSION),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .done         (done),
        .inside_res   (inside_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #300000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check_result(inside_res);
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(index, value);
    endtask

    task automatic set_image(input int unsigned h, input int unsigned w, input int unsigned lim);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_LIMIT, lim);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
        if (idle_on && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start        <= 1'b1;
        pixel_row    <= row;
        pixel_column <= col;
        do @(posedge clk); while (busy);
        board.note_pixel(row, col);
    endtask

    // hold off until every pending result is back
    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIMENSION;
            3:       return 8191;
            default: return $urandom_range(2, MAX_DIMENSION);
        endcase
    endfunction

    function automatic int unsigned pick_limit();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 256;
            3:       return $urandom_range(257, 1200);
            default: return $urandom_range(2, 200);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(logic [DIM_W-1:0] dim);
        int unsigned span;
        span = 32'(dim);
        if (span == 0)
        begin
            span = 1;
        end
        if (span > MAX_DIMENSION)
        begin
            span = MAX_DIMENSION;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            return PIX_W'($urandom_range(0, 4095));
        end
        return PIX_W'($urandom_range(0, span - 1));
    endfunction

    initial
    begin
        int phase;
        int k;
        board        = new();
        idle_on      = 1'b1;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        pixel_row    <= '0;
        pixel_column <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: corners, outside the image, known in-set points
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd32, 12'd48);
        send_pixel(12'd32, 12'd16);
        send_pixel(12'd32, 12'd0);
        send_pixel(12'd63, 12'd63);
        send_pixel(12'd16, 12'd40);
        send_pixel(12'd48, 12'd56);

        // zero dimensions, limit of one
        drain();
        set_image(0, 0, 1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd4095, 12'd4095);

        // limit of zero
        drain();
        write_reg(REG_LIMIT, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // oversized dimensions
        drain();
        set_image(8191, 8191, 2);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd3072);
        send_pixel(12'd4095, 12'd4095);

        // largest limit, c = 0 runs the whole count
        drain();
        set_image(MAX_DIMENSION, MAX_DIMENSION, 65535);
        send_pixel(12'd2048, 12'd3072);
        send_pixel(12'd0, 12'd0);

        for (phase = 0; phase < 10; phase++)
        begin
            drain();
            set_image(pick_dim(), pick_dim(), pick_limit());
            idle_on = (phase != 4);
            for (k = 0; k < 83; k++)
            begin
                if ($urandom_range(0, 99) == 0)
                begin
                    drain();
                end
                send_pixel(pick_pixel(board.cfg.height), pick_pixel(board.cfg.width));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (board.mismatch_count == 0 && board.pending() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: mandelbrot_escape_test.f
+incdir+sv
sv/mbe_pkg.sv
sv/mbe_div.sv
sv/mbe_front.sv
sv/mbe_queue.sv
sv/mbe_back.sv
sv/mandelbrot_escape_test.sv
test/mandelbrot_escape_test_test.sv
